### design/cstok_pkg.sv
// Shared types and constants for the comment-skipping text tokenizer.
`timescale 1ns / 1ps

package cstok_pkg;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_LINE       = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4,
    MODE_QUOTE      = 3'd5,
    MODE_WORD       = 3'd6
  } mode_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_BREAK = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  // Emitter phase within one queued command
  typedef enum logic [1:0] {
    PH_TOK = 2'd0,
    PH_BRK = 2'd1,
    PH_END = 2'd2
  } phase_e;

  // What one accepted byte asks the emitter to send
  typedef struct packed {
    logic has_tok;  // a finished token
    logic empty;    // token goes out as an empty marker
    logic quoted;   // token came from a quoted string
    logic brk;      // line-break marker
    logic fin;      // end-of-text marker
  } cmd_flags_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Command queue between lexer and emitter
  localparam int QDEPTH = 4;
  localparam int QIDX_W = 2;

  // Stream widths
  localparam int TDATA_W = 24;
  localparam int TUSER_W = 2;

endpackage

### design/cstok_lexer.sv
// Front end: byte classifier and lexer state machine, writes token bytes to the ring.
`timescale 1ns / 1ps

module cstok_lexer
  import cstok_pkg::*;
#(
  parameter int TOKEN_CHARS = 32,
  parameter int RING_AW     = 7,
  parameter int CNT_W       = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               lb_allowed_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic [RING_AW:0]   rel_ptr_i,
  input  logic               cmd_ready_i,
  output logic               cmd_valid_o,
  output cmd_flags_t         cmd_flags_o,
  output logic [RING_AW-1:0] cmd_base_o,
  output logic [CNT_W-1:0]   cmd_count_o,
  output logic               wr_en_o,
  output logic [RING_AW-1:0] wr_addr_o,
  output logic [7:0]         wr_data_o
);

  localparam int PTR_W = RING_AW + 1;
  localparam int RING  = 1 << RING_AW;
  localparam logic [PTR_W-1:0] USED_MAX = PTR_W'(RING - TOKEN_CHARS);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(TOKEN_CHARS);

  mode_e              mode_q, mode_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               lm_q, lm_d;
  logic [PTR_W-1:0]   base_q, base_d;

  logic [PTR_W-1:0]   used;
  logic               acc;
  logic               is_white;
  logic [CNT_W-1:0]   wr_off;
  logic               fl_tok, fl_q, brk, fin, go_white;

  // Stall while the ring cannot take a full token or the queue is full
  assign used       = base_q - rel_ptr_i;
  assign in_ready_o = cmd_ready_i && (used <= USED_MAX);
  assign acc        = in_valid_i && in_ready_o;
  assign is_white   = (in_byte_i <= CH_SPACE);

  // Lexer next state
  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    lm_d      = lm_q;
    base_d    = base_q;
    wr_en_o   = 1'b0;
    wr_off    = count_q;
    wr_data_o = in_byte_i;
    fl_tok    = 1'b0;
    fl_q      = 1'b0;
    brk       = 1'b0;
    fin       = 1'b0;
    go_white  = 1'b0;
    if (acc) begin
      if (in_byte_i == CH_NUL) begin
        case (mode_q)
          MODE_WORD, MODE_SLASH: fl_tok = 1'b1;
          MODE_QUOTE: begin
            fl_tok = 1'b1;
            fl_q   = 1'b1;
          end
          default: ;
        endcase
        fin    = 1'b1;
        mode_d = MODE_IDLE;
        lm_d   = 1'b0;
      end else begin
        case (mode_q)
          MODE_SLASH: begin
            // the slash already sits at offset 0 with count 1
            if (in_byte_i == CH_SLASH) begin
              mode_d = MODE_LINE;
            end else if (in_byte_i == CH_STAR) begin
              mode_d = MODE_BLOCK;
            end else if (!is_white) begin
              wr_en_o = 1'b1;
              count_d = count_q + CNT_W'(1);
              mode_d  = MODE_WORD;
            end else begin
              fl_tok   = 1'b1;
              go_white = 1'b1;
            end
          end
          MODE_LINE: begin
            if (in_byte_i == CH_NL) go_white = 1'b1;
          end
          MODE_BLOCK: begin
            if (in_byte_i == CH_STAR) mode_d = MODE_BLOCK_STAR;
          end
          MODE_BLOCK_STAR: begin
            if (in_byte_i == CH_SLASH) begin
              mode_d = MODE_IDLE;
            end else if (in_byte_i != CH_STAR) begin
              mode_d = MODE_BLOCK;
            end
          end
          MODE_QUOTE: begin
            if (in_byte_i == CH_QUOTE) begin
              fl_tok = 1'b1;
              fl_q   = 1'b1;
              mode_d = MODE_IDLE;
            end else if (count_q < CNT_MAX) begin
              wr_en_o = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
          MODE_WORD: begin
            if (!is_white) begin
              if (count_q < CNT_MAX) begin
                wr_en_o = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end else begin
              fl_tok   = 1'b1;
              go_white = 1'b1;
            end
          end
          default: begin
            if (is_white) begin
              go_white = 1'b1;
            end else begin
              lm_d   = 1'b0;
              wr_off = '0;
              if (in_byte_i == CH_SLASH) begin
                wr_en_o   = 1'b1;
                wr_data_o = CH_SLASH;
                count_d   = CNT_W'(1);
                mode_d    = MODE_SLASH;
              end else if (in_byte_i == CH_QUOTE) begin
                count_d = '0;
                mode_d  = MODE_QUOTE;
              end else begin
                wr_en_o = 1'b1;
                count_d = CNT_W'(1);
                mode_d  = MODE_WORD;
              end
            end
          end
        endcase
        // whitespace: back to idle, one marker per run holding a newline while line breaks are not allowed
        if (go_white) begin
          mode_d = MODE_IDLE;
          if (in_byte_i == CH_NL && !lb_allowed_i && !lm_q) begin
            brk  = 1'b1;
            lm_d = 1'b1;
          end
        end
      end
      // a finished token hands its bytes to the emitter
      if (fl_tok) base_d = base_q + PTR_W'(count_q);
      if (fl_tok || fin) count_d = '0;
    end
  end

  assign wr_addr_o = base_q[RING_AW-1:0] + RING_AW'(wr_off);

  // Command to the queue
  assign cmd_valid_o         = acc && (fl_tok || brk || fin);
  assign cmd_flags_o.has_tok = fl_tok;
  assign cmd_flags_o.empty   = fl_q ? (count_q == '0) : (count_q >= CNT_MAX);
  assign cmd_flags_o.quoted  = fl_q;
  assign cmd_flags_o.brk     = brk;
  assign cmd_flags_o.fin     = fin;
  assign cmd_base_o          = base_q[RING_AW-1:0];
  assign cmd_count_o         = count_q;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      count_q <= '0;
      lm_q    <= 1'b0;
      base_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
      lm_q    <= lm_d;
      base_q  <= base_d;
    end
  end

endmodule

### design/cstok_emitter.sv
// Back end: command queue, token byte ring and result sequencer with output register.
`timescale 1ns / 1ps

module cstok_emitter
  import cstok_pkg::*;
#(
  parameter int RING_AW     = 7,
  parameter int CNT_W       = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_flags_t         cmd_flags_i,
  input  logic [RING_AW-1:0] cmd_base_i,
  input  logic [CNT_W-1:0]   cmd_count_i,
  input  logic               wr_en_i,
  input  logic [RING_AW-1:0] wr_addr_i,
  input  logic [7:0]         wr_data_i,
  output logic [RING_AW:0]   rel_ptr_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kind_e              out_kind_o,
  output logic [7:0]         out_byte_o,
  output logic [4:0]         out_pos_o,
  output logic [5:0]         out_len_o,
  output logic               out_quoted_o,
  output logic               out_last_o
);

  localparam int PTR_W = RING_AW + 1;
  localparam int RING  = 1 << RING_AW;

  // Command queue
  cmd_flags_t         qf_q [QDEPTH];
  logic [RING_AW-1:0] qb_q [QDEPTH];
  logic [CNT_W-1:0]   qc_q [QDEPTH];
  logic [QIDX_W-1:0]  wp_q, rp_q;
  logic [QIDX_W:0]    qn_q;

  // Token byte ring
  logic [7:0]         mem [RING];
  logic [7:0]         rd_q;

  // Sequencer
  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [PTR_W-1:0]   rel_q, rel_d;
  logic               pop;

  // Output register
  logic               ov_q;
  kind_e              ok_q;
  logic [4:0]         op_q;
  logic [5:0]         ol_q;
  logic               oq_q, olast_q;

  cmd_flags_t         hf;
  logic [RING_AW-1:0] hb;
  logic [CNT_W-1:0]   hc;
  logic               head_v, advance, issue;
  logic               tok_here, brk_here, tok_final;
  kind_e              r_kind;
  logic [4:0]         r_pos;
  logic [5:0]         r_len, idx6;
  logic               r_quoted, r_last;

  assign cmd_ready_o = (qn_q != (QIDX_W + 1)'(QDEPTH));
  assign head_v      = (qn_q != '0);
  assign hf          = qf_q[rp_q];
  assign hb          = qb_q[rp_q];
  assign hc          = qc_q[rp_q];
  assign advance     = !ov_q || out_ready_i;
  assign issue       = advance && head_v;
  assign idx6        = 6'(idx_q);

  // Pick the result for the head command
  always_comb begin
    tok_here  = (phase_q == PH_TOK) && hf.has_tok;
    brk_here  = !tok_here && hf.brk && (phase_q != PH_END);
    tok_final = hf.empty || ((idx_q + CNT_W'(1)) == hc);
    r_kind    = KIND_END;
    r_pos     = '0;
    r_len     = '0;
    r_quoted  = 1'b0;
    r_last    = 1'b1;
    if (tok_here) begin
      r_kind   = hf.empty ? KIND_EMPTY : KIND_CHAR;
      r_quoted = hf.quoted;
      r_last   = tok_final && !hf.brk && !hf.fin;
      if (!hf.empty) begin
        r_pos = idx6[4:0];
        r_len = 6'(hc);
      end
    end else if (brk_here) begin
      r_kind = KIND_BREAK;
      r_last = !hf.fin;
    end
  end

  // Sequencer next state
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    rel_d   = rel_q;
    pop     = 1'b0;
    if (issue) begin
      if (r_last) begin
        pop     = 1'b1;
        phase_d = PH_TOK;
        idx_d   = '0;
        if (hf.has_tok) rel_d = rel_q + PTR_W'(hc);
      end else if (tok_here) begin
        if (tok_final) begin
          phase_d = PH_BRK;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end else begin
        phase_d = PH_END;
      end
    end
  end

  assign rel_ptr_o = rel_q;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      qf_q[wp_q] <= cmd_flags_i;
      qb_q[wp_q] <= cmd_base_i;
      qc_q[wp_q] <= cmd_count_i;
    end
  end

  // Queue pointers and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      qn_q    <= '0;
      phase_q <= PH_TOK;
      idx_q   <= '0;
      rel_q   <= '0;
    end else begin
      if (cmd_valid_i) wp_q <= wp_q + QIDX_W'(1);
      if (pop) rp_q <= rp_q + QIDX_W'(1);
      case ({cmd_valid_i, pop})
        2'b10:   qn_q <= qn_q + (QIDX_W + 1)'(1);
        2'b01:   qn_q <= qn_q - (QIDX_W + 1)'(1);
        default: qn_q <= qn_q;
      endcase
      phase_q <= phase_d;
      idx_q   <= idx_d;
      rel_q   <= rel_d;
    end
  end

  // Ring write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  // Ring read port, held while the output stalls
  always_ff @(posedge clk_i) begin
    if (issue) rd_q <= mem[hb + RING_AW'(idx_q)];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (advance) begin
      ov_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ok_q    <= r_kind;
      op_q    <= r_pos;
      ol_q    <= r_len;
      oq_q    <= r_quoted;
      olast_q <= r_last;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_kind_o   = ok_q;
  assign out_byte_o   = (ok_q == KIND_CHAR) ? rd_q : 8'h00;
  assign out_pos_o    = op_q;
  assign out_len_o    = ol_q;
  assign out_quoted_o = oq_q;
  assign out_last_o   = olast_q;

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qn_q <= (QIDX_W + 1)'(QDEPTH))
    else $error("command queue count out of range");

  // Lexer pushes only when there is room
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> cmd_ready_o)
    else $error("push into full command queue");

  // Character reads stay inside the token
  a_idx_in_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && tok_here && !hf.empty) |-> (idx_q < hc))
    else $error("token read past its length");

endmodule

### design/comment_skipping_text_tokenizer_core.sv
// Top level of the comment-skipping text tokenizer: config register, lexer and emitter.
`timescale 1ns / 1ps
// Takes one text byte per cycle while ring and command queue have room; results leave at one
// per cycle while the output is ready. An accepted byte's command goes into the command queue,
// and its first result then goes into the output register, from which it is taken.
// A byte that ends a token has each token character and any break and end marker sent as results;
// the lexer runs ahead through a 4-entry command queue and a token byte ring of 4 tokens' depth.
// Reset (async, active low) idles the lexer, empties queue and ring, clears the config bit.

module comment_skipping_text_tokenizer_core
  import cstok_pkg::*;
#(
  parameter int TOKEN_CHARS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config: bit 0 = line_breaks_allowed
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  // tdata: [7:0] text_byte
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  // tdata: [7:0] token_byte, [12:8] position, [18:13] token_length, [19] quoted, [23:20] zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  // tuser: [1:0] kind
  output logic [TUSER_W-1:0] m_axis_tuser,
  output logic               m_axis_tlast
);

  localparam int RING_AW = $clog2(TOKEN_CHARS) + 2;
  localparam int CNT_W   = $clog2(TOKEN_CHARS + 1);

  logic               lb_q;
  logic               cmd_valid, cmd_ready;
  cmd_flags_t         cmd_flags;
  logic [RING_AW-1:0] cmd_base;
  logic [CNT_W-1:0]   cmd_count;
  logic               wr_en;
  logic [RING_AW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic [RING_AW:0]   rel_ptr;
  kind_e              o_kind;
  logic [7:0]         o_byte;
  logic [4:0]         o_pos;
  logic [5:0]         o_len;
  logic               o_quoted;

  // Config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q <= 1'b0;
    end else if (cfg_valid_i) begin
      lb_q <= cfg_data_i;
    end
  end

  cstok_lexer #(
    .TOKEN_CHARS (TOKEN_CHARS),
    .RING_AW     (RING_AW),
    .CNT_W       (CNT_W)
  ) u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lb_allowed_i (lb_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .rel_ptr_i    (rel_ptr),
    .cmd_ready_i  (cmd_ready),
    .cmd_valid_o  (cmd_valid),
    .cmd_flags_o  (cmd_flags),
    .cmd_base_o   (cmd_base),
    .cmd_count_o  (cmd_count),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  cstok_emitter #(
    .RING_AW     (RING_AW),
    .CNT_W       (CNT_W)
  ) u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_flags_i  (cmd_flags),
    .cmd_base_i   (cmd_base),
    .cmd_count_i  (cmd_count),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_data_i    (wr_data),
    .rel_ptr_o    (rel_ptr),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (o_kind),
    .out_byte_o   (o_byte),
    .out_pos_o    (o_pos),
    .out_len_o    (o_len),
    .out_quoted_o (o_quoted),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the result item
  assign m_axis_tdata = {4'b0000, o_quoted, o_len, o_pos, o_byte};
  assign m_axis_tuser = o_kind;

endmodule
